/* hw/rtl/i2c_master_register_access_core_macros.svh */
// Assertion macros for the I2C register access core.
// Used by files that check their own logic; expects clk and rst_n in scope.
`ifndef I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define I2CMRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define I2CMRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/i2cmra_pkg.sv */
// Shared types and constants for the I2C register access core.
// No dependencies.
package i2cmra_pkg;

  localparam int MAX_BYTES_DEF = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [6:0] DEV_ADDR_RST   = 7'd24;
  localparam logic [9:0] HALF_TICKS_RST = 10'd10;
  localparam logic [7:0] ACK_TMO_RST    = 8'd250;

  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TMO    = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ITEM_WADDR = 2'd0,
    ITEM_REG   = 2'd1,
    ITEM_DATA  = 2'd2,
    ITEM_RADDR = 2'd3
  } item_kind_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_ST_A  = 5'd1,
    PH_ST_B  = 5'd2,
    PH_TX_L  = 5'd3,
    PH_TX_H  = 5'd4,
    PH_ACK_L = 5'd5,
    PH_ACK_H = 5'd6,
    PH_ACK_W = 5'd7,
    PH_RS_A  = 5'd8,
    PH_RS_B  = 5'd9,
    PH_RS_C  = 5'd10,
    PH_RX_L  = 5'd11,
    PH_RX_H  = 5'd12,
    PH_MA_L  = 5'd13,
    PH_MA_H  = 5'd14,
    PH_SP_A  = 5'd15,
    PH_SP_B  = 5'd16,
    PH_SP_C  = 5'd17
  } phase_t;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [9:0] half_ticks;
    logic [7:0] ack_tmo;
  } cfg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] reg_addr;
    logic [7:0] wr_byte;
    logic       sda;
  } tick_item_t;

  typedef struct packed {
    logic       scl;
    logic       pull;
    logic       busy;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       done;
    logic       err;
  } result_t;

endpackage

/* hw/rtl/i2c_master_register_access_core.sv */
// I2C master for register reads and writes. Each input beat is one bus tick that
// samples SDA and yields one result beat with the SCL/SDA drive, any read byte and
// the status. Ticks are taken one per clock while the output side is not stalled; a
// result is registered first in the queue stage and then in the output register of
// the single-step phase sequencer. Either side may stall without losing beats.
// Depends on i2cmra_pkg, i2cmra_front, i2cmra_queue, i2cmra_back and the macro header.
`include "i2c_master_register_access_core_macros.svh"

module i2c_master_register_access_core #(
  parameter int MAX_BYTES = i2cmra_pkg::MAX_BYTES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [i2cmra_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [i2cmra_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // register_address[7:0], write_byte[15:8], byte_count[20:16], sda_sample[21]
  input  logic [i2cmra_pkg::IN_TDATA_W-1:0]        in_tdata,
  // cmd[1:0]
  input  logic [1:0]                               in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // scl_level[0], sda_pull_low[1], busy_res[2], read_data[10:3], done_res[11],
  // ack_error[12]
  output logic [i2cmra_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // read_valid[0]
  output logic                                     out_tuser,
  output logic                                     out_tlast
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int QW    = $bits(i2cmra_pkg::tick_item_t) + CNT_W;

  i2cmra_pkg::cfg_t       cfg_r, cfg_nxt;
  i2cmra_pkg::tick_item_t fe_item, q_item;
  logic [CNT_W-1:0]       fe_cnt, q_cnt;
  logic [QW-1:0]          q_out;
  logic                   q_full, q_valid, q_pop;
  i2cmra_pkg::result_t    res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        i2cmra_pkg::CFG_DEV_ADDR:   cfg_nxt.dev_addr   = cfg_wdata[6:0];
        i2cmra_pkg::CFG_HALF_TICKS: cfg_nxt.half_ticks = cfg_wdata[9:0];
        i2cmra_pkg::CFG_ACK_TMO:    cfg_nxt.ack_tmo    = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr   <= i2cmra_pkg::DEV_ADDR_RST;
      cfg_r.half_ticks <= i2cmra_pkg::HALF_TICKS_RST;
      cfg_r.ack_tmo    <= i2cmra_pkg::ACK_TMO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  i2cmra_front #(
    .MAX_BYTES (MAX_BYTES),
    .CNT_W     (CNT_W)
  ) u_front (
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .item     (fe_item),
    .item_cnt (fe_cnt)
  );

  assign in_tready = !q_full;

  i2cmra_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data ({fe_cnt, fe_item}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  assign q_cnt  = q_out[QW-1 -: CNT_W];
  assign q_item = i2cmra_pkg::tick_item_t'(q_out[QW-CNT_W-1:0]);

  i2cmra_back #(
    .MAX_BYTES (MAX_BYTES),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item       (q_item),
    .item_cnt   (q_cnt),
    .item_pop   (q_pop),
    .res_ready  (out_tready),
    .res_valid  (out_tvalid),
    .res        (res)
  );

  assign out_tdata = {3'b000, res.err, res.done, res.rd_data, res.busy, res.pull, res.scl};
  assign out_tuser = res.rd_valid;
  assign out_tlast = res.rd_last;

  `I2CMRA_ASSERT_NOW(a_last_with_byte, out_tvalid && out_tlast, out_tuser,
    "read_last without read_valid")
  `I2CMRA_ASSERT_NOW(a_err_with_done, out_tvalid && out_tdata[12], out_tdata[11],
    "ack_error without done")
  `I2CMRA_ASSERT_NOW(a_idle_levels, out_tvalid && !out_tdata[2],
    out_tdata[0] && !out_tdata[1], "idle beat drives the bus")
  `I2CMRA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

/* hw/rtl/i2cmra_front.sv */
// Front end: unpacks an input beat, classifies the command and clamps the count.
// Depends on i2cmra_pkg.
module i2cmra_front #(
  parameter int MAX_BYTES = i2cmra_pkg::MAX_BYTES_DEF,
  parameter int CNT_W     = $clog2(MAX_BYTES + 1)
) (
  input  logic [1:0]                      in_tuser,  // cmd
  input  logic [i2cmra_pkg::IN_TDATA_W-1:0] in_tdata,
  output i2cmra_pkg::tick_item_t          item,
  output logic [CNT_W-1:0]                item_cnt
);

  localparam int CW = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CW-1:0] MAX_EXT = CW'(MAX_BYTES);
  localparam logic [CW-1:0] ONE_EXT = CW'(1);

  logic [CW-1:0] cnt_ext;
  logic [CW-1:0] cnt_clamp;

  assign cnt_ext = CW'(in_tdata[20:16]);

  always_comb begin
    if (cnt_ext == '0) begin
      cnt_clamp = ONE_EXT;
    end else if (cnt_ext > MAX_EXT) begin
      cnt_clamp = MAX_EXT;
    end else begin
      cnt_clamp = cnt_ext;
    end
  end

  assign item_cnt      = cnt_clamp[CNT_W-1:0];
  assign item.cmd      = i2cmra_pkg::cmd_t'(in_tuser);
  assign item.reg_addr = in_tdata[7:0];
  assign item.wr_byte  = in_tdata[15:8];
  assign item.sda      = in_tdata[21];

endmodule

/* hw/rtl/i2cmra_queue.sv */
// Two-entry queue between the front end and the bus sequencer.
// Depends on nothing but its width parameter.
module i2cmra_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0] slot_r [2];
  logic          wptr_r, wptr_nxt;
  logic          rptr_r, rptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/i2cmra_back.sv */
// Bus sequencer: steps the I2C phase machine once per tick, holds the write buffer
// and registers the result beat. Depends on i2cmra_pkg.
module i2cmra_back #(
  parameter int MAX_BYTES = i2cmra_pkg::MAX_BYTES_DEF,
  parameter int CNT_W     = $clog2(MAX_BYTES + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  i2cmra_pkg::cfg_t       cfg,
  input  logic                   item_valid,
  input  i2cmra_pkg::tick_item_t item,
  input  logic [CNT_W-1:0]       item_cnt,
  output logic                   item_pop,
  input  logic                   res_ready,
  output logic                   res_valid,
  output i2cmra_pkg::result_t    res
);

  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

  i2cmra_pkg::phase_t     phase_r, phase_nxt;
  i2cmra_pkg::item_kind_t kind_r, kind_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       shreg_r, shreg_nxt;
  logic [9:0]       tick_r, tick_nxt;
  logic [7:0]       wait_r, wait_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             rmode_r, rmode_nxt;
  logic [7:0]       hreg_r, hreg_nxt;
  logic [CNT_W-1:0] hcnt_r, hcnt_nxt;
  logic             abort_r, abort_nxt;
  logic             res_valid_r;
  i2cmra_pkg::result_t res_r, res_nxt;

  logic [7:0]       wbuf_r [MAX_BYTES];
  logic             buf_we;
  logic [IDX_W-1:0] buf_raddr;
  logic [7:0]       buf_rdata;

  logic [9:0]       half_eff;
  logic [7:0]       tmo_eff;
  logic             half_over;
  logic [9:0]       tick_inc;
  logic [9:0]       tick_adv;
  logic [CNT_W-1:0] idx_inc;
  logic [7:0]       wait_inc;
  logic [7:0]       sh_in;
  logic             step;

  assign step     = item_valid && (!res_valid_r || res_ready);
  assign item_pop = step;

  assign half_eff  = (cfg.half_ticks == '0) ? 10'd1 : cfg.half_ticks;
  assign tmo_eff   = (cfg.ack_tmo == '0) ? 8'd1 : cfg.ack_tmo;
  assign tick_inc  = tick_r + 10'd1;
  assign half_over = ({1'b0, tick_r} + 11'd1) >= {1'b0, half_eff};
  assign tick_adv  = half_over ? 10'd0 : tick_inc;
  assign idx_inc   = idx_r + CNT_W'(1);
  assign wait_inc  = wait_r + 8'd1;
  assign sh_in     = {shreg_r[6:0], item.sda};

  // first data byte after the register byte, else the one after the current
  assign buf_raddr = (kind_r == i2cmra_pkg::ITEM_REG) ? '0 : idx_inc[IDX_W-1:0];
  assign buf_rdata = wbuf_r[buf_raddr];

  assign buf_we = step && (phase_r == i2cmra_pkg::PH_IDLE) &&
                  (item.cmd == i2cmra_pkg::CMD_PUSH) && (fill_r < MAX_CNT);

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    bit_nxt   = bit_r;
    idx_nxt   = idx_r;
    shreg_nxt = shreg_r;
    tick_nxt  = tick_r;
    wait_nxt  = wait_r;
    fill_nxt  = fill_r;
    rmode_nxt = rmode_r;
    hreg_nxt  = hreg_r;
    hcnt_nxt  = hcnt_r;
    abort_nxt = abort_r;

    res_nxt      = '0;
    res_nxt.scl  = 1'b1;
    res_nxt.busy = (phase_r != i2cmra_pkg::PH_IDLE);

    // bus levels for this tick
    case (phase_r)
      i2cmra_pkg::PH_ST_B, i2cmra_pkg::PH_RS_C, i2cmra_pkg::PH_SP_B: begin
        res_nxt.pull = 1'b1;
      end
      i2cmra_pkg::PH_TX_L, i2cmra_pkg::PH_TX_H: begin
        res_nxt.scl  = (phase_r == i2cmra_pkg::PH_TX_H);
        res_nxt.pull = !shreg_r[7];
      end
      i2cmra_pkg::PH_MA_L, i2cmra_pkg::PH_MA_H: begin
        res_nxt.scl  = (phase_r == i2cmra_pkg::PH_MA_H);
        res_nxt.pull = (idx_inc < hcnt_r);
      end
      i2cmra_pkg::PH_ACK_L, i2cmra_pkg::PH_RS_A, i2cmra_pkg::PH_RX_L: begin
        res_nxt.scl = 1'b0;
      end
      i2cmra_pkg::PH_SP_A: begin
        res_nxt.scl  = 1'b0;
        res_nxt.pull = 1'b1;
      end
      default: begin
      end
    endcase

    case (phase_r)
      i2cmra_pkg::PH_ST_A: begin
        tick_nxt = tick_adv;
        if (half_over) phase_nxt = i2cmra_pkg::PH_ST_B;
      end
      i2cmra_pkg::PH_ST_B: begin
        tick_nxt = tick_adv;
        if (half_over) begin
          shreg_nxt = {cfg.dev_addr, 1'b0};
          kind_nxt  = i2cmra_pkg::ITEM_WADDR;
          bit_nxt   = 3'd0;
          phase_nxt = i2cmra_pkg::PH_TX_L;
        end
      end
      i2cmra_pkg::PH_TX_L: begin
        tick_nxt = tick_adv;
        if (half_over) phase_nxt = i2cmra_pkg::PH_TX_H;
      end
      i2cmra_pkg::PH_TX_H: begin
        tick_nxt = tick_adv;
        if (half_over) begin
          shreg_nxt = {shreg_r[6:0], 1'b0};
          bit_nxt   = bit_r + 3'd1;
          phase_nxt = (bit_r == 3'd7) ? i2cmra_pkg::PH_ACK_L : i2cmra_pkg::PH_TX_L;
        end
      end
      i2cmra_pkg::PH_ACK_L: begin
        tick_nxt = tick_adv;
        if (half_over) phase_nxt = i2cmra_pkg::PH_ACK_H;
      end
      i2cmra_pkg::PH_ACK_H: begin
        tick_nxt = tick_adv;
        if (half_over) begin
          wait_nxt  = 8'd0;
          phase_nxt = i2cmra_pkg::PH_ACK_W;
        end
      end
      i2cmra_pkg::PH_ACK_W: begin
        if (!item.sda) begin
          wait_nxt = 8'd0;
          tick_nxt = 10'd0;
          case (kind_r)
            i2cmra_pkg::ITEM_WADDR: begin
              shreg_nxt = hreg_r;
              kind_nxt  = i2cmra_pkg::ITEM_REG;
              bit_nxt   = 3'd0;
              phase_nxt = i2cmra_pkg::PH_TX_L;
            end
            i2cmra_pkg::ITEM_REG: begin
              if (rmode_r) begin
                phase_nxt = i2cmra_pkg::PH_RS_A;
              end else begin
                idx_nxt   = '0;
                shreg_nxt = buf_rdata;
                kind_nxt  = i2cmra_pkg::ITEM_DATA;
                bit_nxt   = 3'd0;
                phase_nxt = i2cmra_pkg::PH_TX_L;
              end
            end
            i2cmra_pkg::ITEM_DATA: begin
              idx_nxt = idx_inc;
              if (idx_inc >= hcnt_r) begin
                phase_nxt = i2cmra_pkg::PH_SP_A;
              end else begin
                shreg_nxt = buf_rdata;
                bit_nxt   = 3'd0;
                phase_nxt = i2cmra_pkg::PH_TX_L;
              end
            end
            default: begin
              idx_nxt   = '0;
              bit_nxt   = 3'd0;
              shreg_nxt = 8'd0;
              phase_nxt = i2cmra_pkg::PH_RX_L;
            end
          endcase
        end else begin
          wait_nxt = wait_inc;
          // no ack in time: abort straight into stop
          if (wait_inc >= tmo_eff) begin
            wait_nxt  = 8'd0;
            abort_nxt = 1'b1;
            tick_nxt  = 10'd0;
            phase_nxt = i2cmra_pkg::PH_SP_A;
          end
        end
      end
      i2cmra_pkg::PH_RS_A: begin
        tick_nxt = tick_adv;
        if (half_over) phase_nxt = i2cmra_pkg::PH_RS_B;
      end
      i2cmra_pkg::PH_RS_B: begin
        tick_nxt = tick_adv;
        if (half_over) phase_nxt = i2cmra_pkg::PH_RS_C;
      end
      i2cmra_pkg::PH_RS_C: begin
        tick_nxt = tick_adv;
        if (half_over) begin
          shreg_nxt = {cfg.dev_addr, 1'b1};
          kind_nxt  = i2cmra_pkg::ITEM_RADDR;
          bit_nxt   = 3'd0;
          phase_nxt = i2cmra_pkg::PH_TX_L;
        end
      end
      i2cmra_pkg::PH_RX_L: begin
        tick_nxt = tick_adv;
        if (half_over) phase_nxt = i2cmra_pkg::PH_RX_H;
      end
      i2cmra_pkg::PH_RX_H: begin
        tick_nxt = tick_adv;
        // sample on the first tick of the high half
        if (tick_r == 10'd0) begin
          shreg_nxt = sh_in;
          if (bit_r == 3'd7) begin
            res_nxt.rd_valid = 1'b1;
            res_nxt.rd_data  = sh_in;
            res_nxt.rd_last  = (idx_inc >= hcnt_r);
          end
        end
        if (half_over) begin
          bit_nxt   = bit_r + 3'd1;
          phase_nxt = (bit_r == 3'd7) ? i2cmra_pkg::PH_MA_L : i2cmra_pkg::PH_RX_L;
        end
      end
      i2cmra_pkg::PH_MA_L: begin
        tick_nxt = tick_adv;
        if (half_over) phase_nxt = i2cmra_pkg::PH_MA_H;
      end
      i2cmra_pkg::PH_MA_H: begin
        tick_nxt = tick_adv;
        if (half_over) begin
          idx_nxt = idx_inc;
          if (idx_inc >= hcnt_r) begin
            phase_nxt = i2cmra_pkg::PH_SP_A;
          end else begin
            bit_nxt   = 3'd0;
            shreg_nxt = 8'd0;
            phase_nxt = i2cmra_pkg::PH_RX_L;
          end
        end
      end
      i2cmra_pkg::PH_SP_A: begin
        tick_nxt = tick_adv;
        if (half_over) phase_nxt = i2cmra_pkg::PH_SP_B;
      end
      i2cmra_pkg::PH_SP_B: begin
        tick_nxt = tick_adv;
        if (half_over) phase_nxt = i2cmra_pkg::PH_SP_C;
      end
      i2cmra_pkg::PH_SP_C: begin
        tick_nxt = tick_adv;
        if (half_over) begin
          res_nxt.done = 1'b1;
          res_nxt.err  = abort_r;
          abort_nxt    = 1'b0;
          if (!rmode_r) fill_nxt = '0;
          phase_nxt = i2cmra_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = i2cmra_pkg::PH_IDLE;
        case (item.cmd)
          i2cmra_pkg::CMD_PUSH: begin
            if (fill_r < MAX_CNT) fill_nxt = fill_r + CNT_W'(1);
          end
          i2cmra_pkg::CMD_WRITE, i2cmra_pkg::CMD_READ: begin
            hreg_nxt  = item.reg_addr;
            hcnt_nxt  = item_cnt;
            rmode_nxt = (item.cmd == i2cmra_pkg::CMD_READ);
            bit_nxt   = 3'd0;
            idx_nxt   = '0;
            shreg_nxt = 8'd0;
            wait_nxt  = 8'd0;
            abort_nxt = 1'b0;
            tick_nxt  = 10'd0;
            phase_nxt = i2cmra_pkg::PH_ST_A;
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cmra_pkg::PH_IDLE;
      kind_r      <= i2cmra_pkg::ITEM_WADDR;
      bit_r       <= 3'd0;
      idx_r       <= '0;
      shreg_r     <= 8'd0;
      tick_r      <= 10'd0;
      wait_r      <= 8'd0;
      fill_r      <= '0;
      rmode_r     <= 1'b0;
      hreg_r      <= 8'd0;
      hcnt_r      <= '0;
      abort_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        bit_r   <= bit_nxt;
        idx_r   <= idx_nxt;
        shreg_r <= shreg_nxt;
        tick_r  <= tick_nxt;
        wait_r  <= wait_nxt;
        fill_r  <= fill_nxt;
        rmode_r <= rmode_nxt;
        hreg_r  <= hreg_nxt;
        hcnt_r  <= hcnt_nxt;
        abort_r <= abort_nxt;
      end
      if (step) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
    if (buf_we) begin
      wbuf_r[fill_r[IDX_W-1:0]] <= item.wr_byte;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for i2c_master_register_access_core: streams bus ticks, plays
// the I2C target on SDA and checks every result beat against a cycle-level bus predictor.
// Depends on i2cmra_pkg and the core RTL.
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int BUF_DEPTH      = i2cmra_pkg::MAX_BYTES_DEF;

  typedef struct packed {
    i2cmra_pkg::cmd_t cmd;
    logic [7:0]       reg_addr;
    logic [7:0]       wr_byte;
    logic [4:0]       count;
    logic             sda;
  } tick_t;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [i2cmra_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [i2cmra_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [i2cmra_pkg::IN_TDATA_W-1:0] in_tdata;
  logic [1:0]                        in_tuser;
  logic                              out_tvalid;
  logic                              out_tready;
  logic [i2cmra_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              out_tuser;
  logic                              out_tlast;

  int send_idle_pct;
  int recv_idle_pct;
  int error_count  = 0;
  int quiet_cycles = 0;
  i2cmra_pkg::result_t expected_beats[$];

  // predictor copy of the configuration and bus sequencer
  logic [6:0]             dev_addr;
  logic [9:0]             half_ticks;
  logic [7:0]             ack_tmo;
  i2cmra_pkg::phase_t     line_phase;
  i2cmra_pkg::item_kind_t sending;
  logic [3:0]             bit_cnt;
  logic [4:0]             byte_pos;
  logic [7:0]             shift_q;
  logic [9:0]             half_cnt;
  logic [7:0]             ack_wait;
  logic [4:0]             wbuf_fill;
  logic                   txn_read;
  logic [7:0]             txn_reg;
  logic [4:0]             txn_len;
  logic                   abort_pend;
  logic [7:0]             wbuf [BUF_DEPTH];

  // target behavior for the current transfer
  int                     ack_high_pct;
  bit                     refuse_on;
  i2cmra_pkg::item_kind_t refuse_kind;

  i2c_master_register_access_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit half_elapsed();
    int span;
    span = (half_ticks == 10'd0) ? 1 : int'(half_ticks);
    if (int'(half_cnt) + 1 >= span) begin
      half_cnt = '0;
      return 1'b1;
    end
    half_cnt = half_cnt + 10'd1;
    return 1'b0;
  endfunction

  function automatic void enter(i2cmra_pkg::phase_t nxt);
    line_phase = nxt;
    half_cnt   = '0;
  endfunction

  function automatic void load_byte(logic [7:0] b, i2cmra_pkg::item_kind_t k);
    shift_q = b;
    sending = k;
    bit_cnt = '0;
    enter(i2cmra_pkg::PH_TX_L);
  endfunction

  // Advance the bus sequencer by one tick and return the beat it drives.
  function automatic i2cmra_pkg::result_t predict_bus(tick_t t);
    i2cmra_pkg::result_t r;
    int                  tmo;
    int                  len;
    r      = '0;
    r.scl  = 1'b1;
    r.busy = (line_phase != i2cmra_pkg::PH_IDLE);
    tmo    = (ack_tmo == 8'd0) ? 1 : int'(ack_tmo);

    case (line_phase)
      i2cmra_pkg::PH_ST_B, i2cmra_pkg::PH_RS_C, i2cmra_pkg::PH_SP_B: r.pull = 1'b1;
      i2cmra_pkg::PH_TX_L, i2cmra_pkg::PH_TX_H: begin
        r.scl  = (line_phase == i2cmra_pkg::PH_TX_H);
        r.pull = ~shift_q[7];
      end
      i2cmra_pkg::PH_MA_L, i2cmra_pkg::PH_MA_H: begin
        r.scl  = (line_phase == i2cmra_pkg::PH_MA_H);
        r.pull = (int'(byte_pos) + 1 < int'(txn_len));
      end
      i2cmra_pkg::PH_ACK_L, i2cmra_pkg::PH_RS_A, i2cmra_pkg::PH_RX_L: r.scl = 1'b0;
      i2cmra_pkg::PH_SP_A: begin
        r.scl  = 1'b0;
        r.pull = 1'b1;
      end
      default: ;
    endcase

    case (line_phase)
      i2cmra_pkg::PH_ST_A: if (half_elapsed()) enter(i2cmra_pkg::PH_ST_B);
      i2cmra_pkg::PH_ST_B: begin
        if (half_elapsed()) load_byte({dev_addr, 1'b0}, i2cmra_pkg::ITEM_WADDR);
      end
      i2cmra_pkg::PH_TX_L: if (half_elapsed()) enter(i2cmra_pkg::PH_TX_H);
      i2cmra_pkg::PH_TX_H: if (half_elapsed()) begin
        shift_q = shift_q << 1;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          bit_cnt = '0;
          enter(i2cmra_pkg::PH_ACK_L);
        end else begin
          enter(i2cmra_pkg::PH_TX_L);
        end
      end
      i2cmra_pkg::PH_ACK_L: if (half_elapsed()) enter(i2cmra_pkg::PH_ACK_H);
      i2cmra_pkg::PH_ACK_H: if (half_elapsed()) begin
        ack_wait = '0;
        enter(i2cmra_pkg::PH_ACK_W);
      end
      i2cmra_pkg::PH_ACK_W: if (!t.sda) begin
        ack_wait = '0;
        case (sending)
          i2cmra_pkg::ITEM_WADDR: load_byte(txn_reg, i2cmra_pkg::ITEM_REG);
          i2cmra_pkg::ITEM_REG: if (txn_read) begin
            enter(i2cmra_pkg::PH_RS_A);
          end else begin
            byte_pos = '0;
            load_byte(wbuf[0], i2cmra_pkg::ITEM_DATA);
          end
          i2cmra_pkg::ITEM_DATA: begin
            byte_pos = byte_pos + 5'd1;
            if (byte_pos >= txn_len) enter(i2cmra_pkg::PH_SP_A);
            else load_byte(wbuf[byte_pos[3:0]], i2cmra_pkg::ITEM_DATA);
          end
          default: begin
            byte_pos = '0;
            bit_cnt  = '0;
            shift_q  = '0;
            enter(i2cmra_pkg::PH_RX_L);
          end
        endcase
      end else begin
        // every high sample counts toward the timeout
        ack_wait = ack_wait + 8'd1;
        if (int'(ack_wait) >= tmo) begin
          ack_wait   = '0;
          abort_pend = 1'b1;
          enter(i2cmra_pkg::PH_SP_A);
        end
      end
      i2cmra_pkg::PH_RS_A: if (half_elapsed()) enter(i2cmra_pkg::PH_RS_B);
      i2cmra_pkg::PH_RS_B: if (half_elapsed()) enter(i2cmra_pkg::PH_RS_C);
      i2cmra_pkg::PH_RS_C: begin
        if (half_elapsed()) load_byte({dev_addr, 1'b1}, i2cmra_pkg::ITEM_RADDR);
      end
      i2cmra_pkg::PH_RX_L: if (half_elapsed()) enter(i2cmra_pkg::PH_RX_H);
      i2cmra_pkg::PH_RX_H: begin
        // take the data bit on the first tick of SCL high
        if (half_cnt == 10'd0) begin
          shift_q = {shift_q[6:0], t.sda};
          if (bit_cnt == 4'd7) begin
            r.rd_valid = 1'b1;
            r.rd_data  = shift_q;
            r.rd_last  = (int'(byte_pos) + 1 >= int'(txn_len));
          end
        end
        if (half_elapsed()) begin
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            bit_cnt = '0;
            enter(i2cmra_pkg::PH_MA_L);
          end else begin
            enter(i2cmra_pkg::PH_RX_L);
          end
        end
      end
      i2cmra_pkg::PH_MA_L: if (half_elapsed()) enter(i2cmra_pkg::PH_MA_H);
      i2cmra_pkg::PH_MA_H: if (half_elapsed()) begin
        byte_pos = byte_pos + 5'd1;
        if (byte_pos >= txn_len) begin
          enter(i2cmra_pkg::PH_SP_A);
        end else begin
          bit_cnt = '0;
          shift_q = '0;
          enter(i2cmra_pkg::PH_RX_L);
        end
      end
      i2cmra_pkg::PH_SP_A: if (half_elapsed()) enter(i2cmra_pkg::PH_SP_B);
      i2cmra_pkg::PH_SP_B: if (half_elapsed()) enter(i2cmra_pkg::PH_SP_C);
      i2cmra_pkg::PH_SP_C: if (half_elapsed()) begin
        r.done     = 1'b1;
        r.err      = abort_pend;
        abort_pend = 1'b0;
        if (!txn_read) wbuf_fill = '0;
        enter(i2cmra_pkg::PH_IDLE);
      end
      default: begin
        if (t.cmd == i2cmra_pkg::CMD_PUSH) begin
          if (int'(wbuf_fill) < BUF_DEPTH) begin
            wbuf[wbuf_fill[3:0]] = t.wr_byte;
            wbuf_fill = wbuf_fill + 5'd1;
          end
        end else if (t.cmd == i2cmra_pkg::CMD_WRITE || t.cmd == i2cmra_pkg::CMD_READ) begin
          len = (t.count == 5'd0) ? 1 : int'(t.count);
          if (len > BUF_DEPTH) len = BUF_DEPTH;
          txn_reg    = t.reg_addr;
          txn_len    = 5'(len);
          txn_read   = (t.cmd == i2cmra_pkg::CMD_READ);
          bit_cnt    = '0;
          byte_pos   = '0;
          shift_q    = '0;
          ack_wait   = '0;
          abort_pend = 1'b0;
          enter(i2cmra_pkg::PH_ST_A);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic target_sda();
    if (line_phase == i2cmra_pkg::PH_ACK_W) begin
      if (refuse_on && sending == refuse_kind) return 1'b1;
      return ($urandom_range(99) < ack_high_pct);
    end
    return 1'($urandom_range(1));
  endfunction

  function automatic tick_t random_tick(i2cmra_pkg::cmd_t c);
    tick_t t;
    t.cmd      = c;
    t.reg_addr = 8'($urandom);
    t.wr_byte  = 8'($urandom);
    t.count    = 5'($urandom);
    t.sda      = target_sda();
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = t.cmd;
    in_tdata  = {2'b00, t.sda, t.count, t.wr_byte, t.reg_addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_beats.push_back(predict_bus(t));
  endtask

  task automatic push_byte(logic [7:0] b);
    tick_t t;
    t = random_tick(i2cmra_pkg::CMD_PUSH);
    t.wr_byte = b;
    send_tick(t);
  endtask

  // Issue one command from idle.
  task automatic start_transfer(bit rd, logic [7:0] reg_addr, logic [4:0] len, int high_pct,
                                bit refuse, i2cmra_pkg::item_kind_t kind);
    tick_t t;
    ack_high_pct = high_pct;
    refuse_on    = refuse;
    refuse_kind  = kind;
    t = random_tick(rd ? i2cmra_pkg::CMD_READ : i2cmra_pkg::CMD_WRITE);
    t.reg_addr = reg_addr;
    t.count    = len;
    send_tick(t);
  endtask

  // one tick during a transfer; now and then a command, which must be dropped
  task automatic busy_tick();
    i2cmra_pkg::cmd_t c;
    c = ($urandom_range(9) == 0) ? i2cmra_pkg::cmd_t'($urandom_range(3))
                                 : i2cmra_pkg::CMD_TICK;
    send_tick(random_tick(c));
  endtask

  task automatic finish_transfer();
    while (line_phase != i2cmra_pkg::PH_IDLE) busy_tick();
  endtask

  task automatic run_transfer(bit rd, logic [7:0] reg_addr, logic [4:0] len, int high_pct,
                              bit refuse = 1'b0,
                              i2cmra_pkg::item_kind_t kind = i2cmra_pkg::ITEM_WADDR);
    start_transfer(rd, reg_addr, len, high_pct, refuse, kind);
    finish_transfer();
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [6:0] dev, logic [9:0] half, logic [7:0] tmo);
    settle();
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      case (i)
        0: begin
          cfg_addr  = i2cmra_pkg::CFG_DEV_ADDR;
          cfg_wdata = i2cmra_pkg::CFG_DATA_W'(dev);
        end
        1: begin
          cfg_addr  = i2cmra_pkg::CFG_HALF_TICKS;
          cfg_wdata = i2cmra_pkg::CFG_DATA_W'(half);
        end
        default: begin
          cfg_addr  = i2cmra_pkg::CFG_ACK_TMO;
          cfg_wdata = i2cmra_pkg::CFG_DATA_W'(tmo);
        end
      endcase
    end
    @(negedge clk);
    cfg_we     = 1'b0;
    dev_addr   = dev;
    half_ticks = half;
    ack_tmo    = tmo;
  endtask

  task automatic test_defaults();
    push_byte(8'h3C);
    start_transfer(1'b0, 8'h20, 5'd1, 0, 1'b0, i2cmra_pkg::ITEM_WADDR);
    // reset timing through start and into the first address bit
    repeat (34) busy_tick();
    // zero timing registers behave as one; finish the transfer that way
    set_config(7'd0, 10'd0, 8'd0);
    finish_transfer();
  endtask

  task automatic test_ack_timeout();
    set_config(7'h2A, 10'd1, 8'd2);
    run_transfer(1'b0, 8'h10, 5'd2, 0, 1'b1, i2cmra_pkg::ITEM_WADDR);
    run_transfer(1'b1, 8'h13, 5'd2, 0, 1'b1, i2cmra_pkg::ITEM_RADDR);
  endtask

  task automatic test_full_buffer();
    set_config(7'd127, 10'd1, 8'd6);
    push_byte(8'hFF);
    push_byte(8'h00);
    for (int i = 2; i < BUF_DEPTH; i++) push_byte(8'($urandom));
    push_byte(8'hA5);                          // buffer full, dropped
    run_transfer(1'b0, 8'h00, 5'd31, 40);      // oversized count clamps to the buffer depth
  endtask

  task automatic test_zero_count();
    set_config(7'h55, 10'd1, 8'd4);
    run_transfer(1'b1, 8'h55, 5'd0, 50);
  endtask

  always @(negedge clk) out_tready = ($urandom_range(99) >= recv_idle_pct);

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    i2cmra_pkg::result_t got;
    i2cmra_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.scl      = out_tdata[0];
      got.pull     = out_tdata[1];
      got.busy     = out_tdata[2];
      got.rd_data  = out_tdata[10:3];
      got.done     = out_tdata[11];
      got.err      = out_tdata[12];
      got.rd_valid = out_tuser;
      got.rd_last  = out_tlast;
      if (expected_beats.size() == 0) begin
        $error("result beat arrived with nothing expected");
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("scl_level", 8'(want.scl), 8'(got.scl));
        check_field("sda_pull_low", 8'(want.pull), 8'(got.pull));
        check_field("busy_res", 8'(want.busy), 8'(got.busy));
        check_field("read_data", want.rd_data, got.rd_data);
        check_field("read_valid", 8'(want.rd_valid), 8'(got.rd_valid));
        check_field("read_last", 8'(want.rd_last), 8'(got.rd_last));
        check_field("done_res", 8'(want.done), 8'(got.done));
        check_field("ack_error", 8'(want.err), 8'(got.err));
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = i2cmra_pkg::CFG_DEV_ADDR;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = i2cmra_pkg::CMD_TICK;
    ack_high_pct = 0;
    refuse_on   = 1'b0;
    refuse_kind = i2cmra_pkg::ITEM_WADDR;
    send_idle_pct = 21;
    recv_idle_pct = 64;

    dev_addr   = i2cmra_pkg::DEV_ADDR_RST;
    half_ticks = i2cmra_pkg::HALF_TICKS_RST;
    ack_tmo    = i2cmra_pkg::ACK_TMO_RST;
    line_phase = i2cmra_pkg::PH_IDLE;
    sending    = i2cmra_pkg::ITEM_WADDR;
    bit_cnt    = '0;
    byte_pos   = '0;
    shift_q    = '0;
    half_cnt   = '0;
    ack_wait   = '0;
    wbuf_fill  = '0;
    txn_read   = 1'b0;
    txn_reg    = '0;
    txn_len    = '0;
    abort_pend = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_defaults();
    test_ack_timeout();

    send_idle_pct = 64;
    recv_idle_pct = 21;
    test_full_buffer();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_zero_count();

    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/i2cmra_pkg.sv
hw/rtl/i2cmra_front.sv
hw/rtl/i2cmra_queue.sv
hw/rtl/i2cmra_back.sv
hw/rtl/i2c_master_register_access_core.sv
tb/testbench.sv
